// ===== hdl/rsv_pkg.sv =====
// Shared types, widths and constants of the revolution-surface vertex generator.
`default_nettype none

package rsv_pkg;

    localparam int COORD_W       = 32;
    localparam int FRAC_BITS     = 16;
    localparam int TEX_W         = FRAC_BITS + 1;
    localparam int IDX_W         = 6;
    localparam int DIVN_W        = 7;
    localparam int CFG_W         = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_DIVISIONS = 64;
    localparam int MAX_PROFILE   = 64;

    localparam int SQ_W          = 2 * COORD_W;
    localparam int SQRT_STEPS    = SQ_W / 2;
    localparam int ROOT_W        = COORD_W - 1;
    localparam int GUARD_BITS    = 16;
    localparam int GAIN_W        = ROOT_W + 32 - (32 - GUARD_BITS);
    localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

    localparam int ROT_STEPS     = 30;
    localparam int CX_W          = GAIN_W + 2;
    localparam int TH_W          = 34;
    localparam int PHASE_W       = 32;
    localparam int QUO_W         = DIVN_W + PHASE_W;

    localparam int SQRT_LAT      = SQRT_STEPS + 2;
    localparam int DIV_LAT       = QUO_W;
    localparam int RAD_DLY       = DIV_LAT - SQRT_LAT;
    localparam int CORDIC_LAT    = ROT_STEPS + 1;
    localparam int POST_DLY      = CORDIC_LAT + 1;
    localparam int PIPE_DEPTH    = DIV_LAT + 1 + CORDIC_LAT;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIVISIONS      = 2'd0,
        CFG_PROFILE_POINTS = 2'd1
    } t_cfg_idx;

    // arctangent of 2^-k in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN [0:ROT_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [IDX_W-1:0]          point_index;
        logic [DIVN_W-1:0]         division_index;
    } t_point;

    typedef struct packed {
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic signed [COORD_W-1:0] vert_z;
        logic [TEX_W-1:0]          tex_s;
        logic [TEX_W-1:0]          tex_t;
    } t_vertex;

endpackage

`default_nettype wire

// ===== hdl/rsv_sqrt.sv =====
// Pipelined radius unit: squares, sum and one root bit per stage.
`default_nettype none

module rsv_sqrt (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [rsv_pkg::COORD_W-1:0] i_x,
    input  wire logic signed [rsv_pkg::COORD_W-1:0] i_z,
    output logic [rsv_pkg::ROOT_W-1:0]             o_root
);
    import rsv_pkg::*;

    localparam int REM_W = SQRT_STEPS + 4;

    logic [COORD_W-1:0]    mag_x, mag_z;
    logic [SQ_W-1:0]       r_sq_x, r_sq_z;
    logic [SQ_W-1:0]       r_rad  [0:SQRT_STEPS];
    logic [REM_W-1:0]      r_rem  [0:SQRT_STEPS];
    logic [SQRT_STEPS-1:0] r_root [0:SQRT_STEPS];

    // magnitude of the most negative value reads correctly as unsigned
    assign mag_x = i_x[COORD_W-1] ? COORD_W'(-i_x) : COORD_W'(i_x);
    assign mag_z = i_z[COORD_W-1] ? COORD_W'(-i_z) : COORD_W'(i_z);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_x    <= SQ_W'(mag_x) * SQ_W'(mag_x);
            r_sq_z    <= SQ_W'(mag_z) * SQ_W'(mag_z);
            r_rad[0]  <= r_sq_x + r_sq_z;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [REM_W-1:0] rem_sh, trial;
        logic             fits;

        assign rem_sh = {r_rem[k][REM_W-3:0], r_rad[k][SQ_W-1 -: 2]};
        assign trial  = REM_W'({r_root[k], 2'b01});
        assign fits   = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k+1]  <= {r_rad[k][SQ_W-3:0], 2'b00};
                r_rem[k+1]  <= fits ? (rem_sh - trial) : rem_sh;
                r_root[k+1] <= {r_root[k][SQRT_STEPS-2:0], fits};
            end
        end
    end

    // saturate to the positive coordinate range
    assign o_root = r_root[SQRT_STEPS][SQRT_STEPS-1] ? {ROOT_W{1'b1}}
                                                     : r_root[SQRT_STEPS][ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/rsv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module rsv_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [rsv_pkg::QUO_W-1:0]  i_num,
    input  wire logic [rsv_pkg::DIVN_W-1:0] i_den,
    output logic [rsv_pkg::QUO_W-1:0]       o_quo
);
    import rsv_pkg::*;

    logic [QUO_W-1:0]  r_num [0:QUO_W-1];
    logic [QUO_W-1:0]  r_quo [0:QUO_W-1];
    logic [DIVN_W-1:0] r_rem [0:QUO_W-1];
    logic [DIVN_W-1:0] r_den [0:QUO_W-1];

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [QUO_W-1:0]  cur_num, cur_quo;
        logic [DIVN_W-1:0] cur_rem, cur_den;
        logic [DIVN_W:0]   part, diff;
        logic              fits;

        if (k == 0) begin : g_first
            assign cur_num = i_num;
            assign cur_quo = '0;
            assign cur_rem = '0;
            assign cur_den = i_den;
        end else begin : g_next
            assign cur_num = r_num[k-1];
            assign cur_quo = r_quo[k-1];
            assign cur_rem = r_rem[k-1];
            assign cur_den = r_den[k-1];
        end

        assign part = {cur_rem, cur_num[QUO_W-1]};
        assign diff = part - {1'b0, cur_den};
        assign fits = (part >= {1'b0, cur_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= {cur_num[QUO_W-2:0], 1'b0};
                r_quo[k] <= {cur_quo[QUO_W-2:0], fits};
                r_rem[k] <= fits ? diff[DIVN_W-1:0] : part[DIVN_W-1:0];
                r_den[k] <= cur_den;
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

`default_nettype wire

// ===== hdl/rsv_cordic.sv =====
// Pipelined CORDIC rotation, one micro-rotation per stage, then round and saturate.
`default_nettype none

module rsv_cordic (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic signed [rsv_pkg::CX_W-1:0]    i_x,
    input  wire logic signed [rsv_pkg::TH_W-1:0]    i_th,
    output logic signed [rsv_pkg::COORD_W-1:0]      o_x,
    output logic signed [rsv_pkg::COORD_W-1:0]      o_z
);
    import rsv_pkg::*;

    localparam logic signed [CX_W-1:0] SAT_HI = CX_W'(2147483647);
    localparam logic signed [CX_W-1:0] SAT_LO = -SAT_HI - CX_W'(1);
    localparam logic signed [CX_W-1:0] HALF   = CX_W'(1) <<< (GUARD_BITS - 1);

    logic signed [CX_W-1:0] r_x  [0:ROT_STEPS-1];
    logic signed [CX_W-1:0] r_y  [0:ROT_STEPS-1];
    logic signed [TH_W-1:0] r_th [0:ROT_STEPS-1];
    logic signed [COORD_W-1:0] r_ox, r_oz;

    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [CX_W-1:0] v
    );
        logic signed [CX_W-1:0] s;
        s = (v + HALF) >>> GUARD_BITS;
        if (s > SAT_HI) begin
            round_sat = SAT_HI[COORD_W-1:0];
        end else if (s < SAT_LO) begin
            round_sat = SAT_LO[COORD_W-1:0];
        end else begin
            round_sat = s[COORD_W-1:0];
        end
    endfunction

    for (genvar k = 0; k < ROT_STEPS; k++) begin : g_step
        logic signed [CX_W-1:0] cx, cy, dx, dy;
        logic signed [TH_W-1:0] cth, ang;

        if (k == 0) begin : g_first
            assign cx  = i_x;
            assign cy  = '0;
            assign cth = i_th;
        end else begin : g_next
            assign cx  = r_x[k-1];
            assign cy  = r_y[k-1];
            assign cth = r_th[k-1];
        end

        assign dx  = cy >>> k;
        assign dy  = cx >>> k;
        assign ang = signed'(TH_W'(ATAN_TURN[k]));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!cth[TH_W-1]) begin
                    r_x[k]  <= cx - dx;
                    r_y[k]  <= cy + dy;
                    r_th[k] <= cth - ang;
                end else begin
                    r_x[k]  <= cx + dx;
                    r_y[k]  <= cy - dy;
                    r_th[k] <= cth + ang;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ox <= round_sat(r_x[ROT_STEPS-1]);
            r_oz <= round_sat(r_y[ROT_STEPS-1]);
        end
    end

    assign o_x = r_ox;
    assign o_z = r_oz;

endmodule

`default_nettype wire

// ===== hdl/revolution_surface_vertex_gen.sv =====
// Top level of the revolution-surface vertex generator: config, alignment, output skid.
//
//  channel   direction  handshake                 beat
//  --------  ---------  ------------------------  -----------------------------------
//  point     in         i_valid / o_stall         i_point  (x, y, z, index, division)
//  vertex    out        o_valid / i_stall         o_vertex (x, y, z, tex_s, tex_t)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One beat enters per cycle while o_stall is low. Each beat passes 39 divider stages
//  for the phase, one prep stage, 30 CORDIC stages, rounding and the output register
//  before o_valid rises. The 34-stage square-root path runs beside the divider, delayed.
//  Reset (synchronous, active low) clears valid bits, output and skid flags, and sets
//  both registers to 16. The pipe advances while the skid is empty; a stalled output
//  parks one beat in the skid, which then freezes the pipeline and raises o_stall.
`default_nettype none

module revolution_surface_vertex_gen (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire rsv_pkg::t_point              i_point,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output rsv_pkg::t_vertex                  o_vertex,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [rsv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rsv_pkg::CFG_W-1:0]    i_cfg_data
);
    import rsv_pkg::*;

    localparam logic [TEX_W-1:0] TEX_ONE = TEX_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic                      s_zero;
        logic                      t_zero;
        logic                      t_full;
    } t_side;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [GAIN_W-1:0] gain;
    } t_rad;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic [TEX_W-1:0]          tex_s;
        logic [TEX_W-1:0]          tex_t;
        logic [ROOT_W-1:0]         root;
        logic                      zero;
    } t_post;

    // configuration
    logic [CFG_W-1:0] r_divisions, r_profile_points;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisions      <= CFG_W'(16);
            r_profile_points <= CFG_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DIVISIONS:      r_divisions      <= i_cfg_data;
                CFG_PROFILE_POINTS: r_profile_points <= i_cfg_data;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // global advance: the whole pipe moves while the skid is empty
    logic en, in_acc;
    logic r_skid_valid, r_out_valid;

    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign in_acc  = i_valid && en;

    // clamp the registers and form the three divider operands
    logic [DIVN_W-1:0] nd_eff, lp_eff, d_den;
    logic [QUO_W-1:0]  num_phase, num_s, num_t;
    t_side             side_in;

    always_comb begin
        if (r_divisions == '0) begin
            nd_eff = DIVN_W'(1);
        end else if (r_divisions > DIVN_W'(MAX_DIVISIONS)) begin
            nd_eff = DIVN_W'(MAX_DIVISIONS);
        end else begin
            nd_eff = r_divisions;
        end
        lp_eff = (r_profile_points > DIVN_W'(MAX_PROFILE)) ? DIVN_W'(MAX_PROFILE)
                                                           : r_profile_points;
        d_den  = (lp_eff < DIVN_W'(2)) ? DIVN_W'(1) : lp_eff - DIVN_W'(1);

        num_phase = {i_point.division_index, {PHASE_W{1'b0}}};
        num_s     = QUO_W'({i_point.division_index, {FRAC_BITS{1'b0}}})
                  | QUO_W'(nd_eff >> 1);
        num_t     = QUO_W'({i_point.point_index, {FRAC_BITS{1'b0}}})
                  | QUO_W'(d_den >> 1);

        side_in.y      = i_point.point_y;
        side_in.s_zero = (i_point.division_index >= nd_eff);
        side_in.t_zero = (lp_eff < DIVN_W'(2));
        side_in.t_full = (DIVN_W'(i_point.point_index) >= d_den);
    end

    // valid bits travel beside the data
    logic [PIPE_DEPTH-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], in_acc};
        end
    end

    // dividers: phase fraction and both texture quotients
    logic [QUO_W-1:0] quo_phase, quo_s, quo_t;

    rsv_div u_div_phase (
        .i_clk (i_clk), .i_en (en), .i_num (num_phase), .i_den (nd_eff), .o_quo (quo_phase)
    );
    rsv_div u_div_s (
        .i_clk (i_clk), .i_en (en), .i_num (num_s), .i_den (nd_eff), .o_quo (quo_s)
    );
    rsv_div u_div_t (
        .i_clk (i_clk), .i_en (en), .i_num (num_t), .i_den (d_den), .o_quo (quo_t)
    );

    // radius path
    logic [ROOT_W-1:0] root;

    rsv_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (i_point.point_x),
        .i_z    (i_point.point_z),
        .o_root (root)
    );

    // hold side data until the dividers finish
    t_side r_side [0:DIV_LAT-1];
    t_rad  r_rad  [0:RAD_DLY-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0]      <= side_in;
            r_rad[0].root  <= root;
            r_rad[0].gain  <= GAIN_W'((SQ_W'(root) * SQ_W'(GAIN_Q32)) >> (32 - GUARD_BITS));
            for (int k = 1; k < DIV_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 1; k < RAD_DLY; k++) begin
                r_rad[k] <= r_rad[k-1];
            end
        end
    end

    // prep stage: fold the phase into the CORDIC range, finish the texture pair
    logic [PHASE_W-1:0] phase, phase_f;
    logic               fold;
    t_side              side_d;
    t_rad               rad_d;
    t_post              post_in;
    logic signed [CX_W-1:0] cx0;
    logic signed [CX_W-1:0] r_cx;
    logic signed [TH_W-1:0] r_cth;
    t_post              r_post [0:POST_DLY-1];

    assign side_d = r_side[DIV_LAT-1];
    assign rad_d  = r_rad[RAD_DLY-1];
    assign phase  = quo_phase[PHASE_W-1:0];
    // second and third quarter turns rotate the negated vector by phase - 1/2
    assign fold    = phase[PHASE_W-1] ^ phase[PHASE_W-2];
    assign phase_f = fold ? {~phase[PHASE_W-1], phase[PHASE_W-2:0]} : phase;
    assign cx0     = fold ? -signed'(CX_W'(rad_d.gain)) : signed'(CX_W'(rad_d.gain));

    always_comb begin
        post_in.y     = side_d.y;
        post_in.tex_s = side_d.s_zero ? '0 : TEX_ONE - quo_s[TEX_W-1:0];
        if (side_d.t_zero) begin
            post_in.tex_t = '0;
        end else if (side_d.t_full) begin
            post_in.tex_t = TEX_ONE;
        end else begin
            post_in.tex_t = quo_t[TEX_W-1:0];
        end
        post_in.root  = rad_d.root;
        post_in.zero  = (phase == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx      <= cx0;
            r_cth     <= TH_W'(signed'(phase_f));
            r_post[0] <= post_in;
            for (int k = 1; k < POST_DLY; k++) begin
                r_post[k] <= r_post[k-1];
            end
        end
    end

    logic signed [COORD_W-1:0] rot_x, rot_z;

    rsv_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_cx),
        .i_th  (r_cth),
        .o_x   (rot_x),
        .o_z   (rot_z)
    );

    // pipe tail: zero phase passes the radius straight through
    t_post   post_d;
    t_vertex pipe_out;
    logic    pipe_valid;

    assign post_d     = r_post[POST_DLY-1];
    assign pipe_valid = r_vld[PIPE_DEPTH-1];

    always_comb begin
        pipe_out.vert_x = post_d.zero ? signed'(COORD_W'(post_d.root)) : rot_x;
        pipe_out.vert_y = post_d.y;
        pipe_out.vert_z = post_d.zero ? '0 : rot_z;
        pipe_out.tex_s  = post_d.tex_s;
        pipe_out.tex_t  = post_d.tex_t;
    end

    // output register plus one-beat skid
    t_vertex r_out, r_skid;
    logic    take;

    assign take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || take) begin
            r_out_valid <= pipe_valid;
        end else if (pipe_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || take) begin
            r_out <= pipe_out;
        end else if (pipe_valid) begin
            r_skid <= pipe_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_vertex = r_out;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while the output register is empty");

    a_frozen_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> $stable(r_vld))
        else $error("pipeline advanced while the skid was full");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (!r_skid_valid && o_valid))
        else $error("skid did not drain into the output register");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the revolution-surface vertex generator.
`default_nettype none

module testbench;
    import rsv_pkg::*;

    localparam int DRAIN_CYCLES = PIPE_DEPTH + 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic    i_valid = 1'b0;
    logic    o_stall;
    t_point  i_point = '0;
    logic    o_valid;
    logic    i_stall = 1'b0;
    t_vertex o_vertex;
    logic    i_cfg_valid = 1'b0;
    logic    o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Register shadows that the vertex predictor reads.
    logic [CFG_W-1:0] division_count = 7'd16;
    logic [CFG_W-1:0] profile_count = 7'd16;

    t_point  pending_points[$];
    t_vertex expected_vertices[$];
    int      mismatch_count = 0;
    bit      steady_stretch = 1'b0;

    revolution_surface_vertex_gen i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_point     (i_point),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_vertex    (o_vertex),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Integer square root, floor, of a 64-bit sum of squares.
    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] probe;
        root = '0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Rotate the profile radius by n/N of a turn and form the texture pair.
    function automatic t_vertex rotate_point(t_point p);
        t_vertex     v;
        longint      px, pz, cx, cy, ang, dx, dy;
        logic [63:0] sq, radius, nd, lp, n, phase, one, ts, tt, span;
        one = 64'd1 << FRAC_BITS;
        nd = 64'(division_count);
        lp = 64'(profile_count);
        n = 64'(p.division_index);
        if (nd == 0) nd = 64'd1;
        if (nd > MAX_DIVISIONS) nd = 64'(MAX_DIVISIONS);
        if (lp > MAX_PROFILE) lp = 64'(MAX_PROFILE);
        px = longint'(p.point_x);
        pz = longint'(p.point_z);
        sq = 64'(px * px) + 64'(pz * pz);
        radius = floor_sqrt(sq);
        if (radius > 64'd2147483647) radius = 64'd2147483647;
        phase = ((n << 32) / nd) & 64'hFFFFFFFF;
        if (phase == 0) begin
            v.vert_x = radius[31:0];
            v.vert_z = '0;
        end else begin
            cx = longint'((radius * {32'd0, GAIN_Q32}) >> (32 - GUARD_BITS));
            cy = '0;
            // fold the angle into the right half-plane, flipping the start vector
            if (phase >= 64'h40000000 && phase < 64'hC0000000) begin
                cx = -cx;
                phase = (phase - 64'h80000000) & 64'hFFFFFFFF;
            end
            ang = longint'(phase);
            if (phase >= 64'h80000000) ang = ang - 64'sh100000000;
            for (int k = 0; k < ROT_STEPS; k++) begin
                dx = cy >>> k;
                dy = cx >>> k;
                if (ang >= 0) begin
                    cx = cx - dx; cy = cy + dy; ang = ang - longint'(ATAN_TURN[k]);
                end else begin
                    cx = cx + dx; cy = cy - dy; ang = ang + longint'(ATAN_TURN[k]);
                end
            end
            v.vert_x = clamp32((cx + (64'sd1 << (GUARD_BITS - 1))) >>> GUARD_BITS);
            v.vert_z = clamp32((cy + (64'sd1 << (GUARD_BITS - 1))) >>> GUARD_BITS);
        end
        v.vert_y = p.point_y;
        if (n >= nd) ts = '0;
        else ts = one - (n * one + nd / 2) / nd;
        if (lp < 2) begin
            tt = '0;
        end else begin
            span = lp - 1;
            if (p.point_index >= span) tt = one;
            else tt = (p.point_index * one + span / 2) / span;
        end
        v.tex_s = ts[TEX_W-1:0];
        v.tex_t = tt[TEX_W-1:0];
        return v;
    endfunction

    // Coordinate with a random magnitude so that small and huge radii both occur.
    function automatic logic [31:0] rand_coord();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(3))
            0: return raw;
            1: return 32'($signed(raw) >>> $urandom_range(31));
            2: return {raw[31], 31'(raw[30:0] >> $urandom_range(30))};
            default: return $urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF;
        endcase
    endfunction

    function automatic t_point rand_point(bit well_formed);
        t_point p;
        int     nd;
        nd = (division_count == 0) ? 1 :
             (division_count > MAX_DIVISIONS) ? MAX_DIVISIONS : division_count;
        p.point_x = rand_coord();
        p.point_y = rand_coord();
        p.point_z = rand_coord();
        if (well_formed) begin
            p.point_index = IDX_W'($urandom_range(63));
            p.division_index = DIVN_W'($urandom_range(nd));
        end else begin
            p.point_index = IDX_W'($urandom);
            p.division_index = DIVN_W'($urandom);
        end
        return p;
    endfunction

    function automatic t_point make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          int idx, int div);
        t_point p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        p.point_index = IDX_W'(idx);
        p.division_index = DIVN_W'(div);
        return p;
    endfunction

    // Append one point to the sender's queue.
    task automatic queue_point(t_point p);
        pending_points = {pending_points, p};
    endtask

    // Wait until every queued point is in and every vertex is out.
    task automatic drain_all();
        while (pending_points.size() != 0 || i_valid || expected_vertices.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx index, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= CFG_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        // indexes past the register list change nothing
        if (index == CFG_DIVISIONS) division_count = CFG_W'(value);
        else if (index == CFG_PROFILE_POINTS) profile_count = CFG_W'(value);
    endtask

    task automatic queue_random(int count);
        for (int k = 0; k < count; k++)
            queue_point(rand_point($urandom_range(99) < 85));
    endtask

    // Point driver: advance only when the current beat was taken or none is up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pending_points.size() != 0 &&
                (steady_stretch || $urandom_range(99) >= 34)) begin
                i_point <= pending_points.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= !steady_stretch && ($urandom_range(99) < 34);
    end

    // Predict on every accepted point, check every accepted vertex.
    always @(posedge i_clk) begin
        t_vertex want;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                expected_vertices = {expected_vertices, rotate_point(i_point)};
            if (o_valid && !i_stall) begin
                if (expected_vertices.size() == 0) begin
                    $error("unexpected vertex beat %p", o_vertex);
                    mismatch_count++;
                end else begin
                    want = expected_vertices.pop_front();
                    if (o_vertex.vert_x !== want.vert_x) begin
                        $error("vert_x: expected %0d, got %0d", want.vert_x, o_vertex.vert_x);
                        mismatch_count++;
                    end
                    if (o_vertex.vert_y !== want.vert_y) begin
                        $error("vert_y: expected %0d, got %0d", want.vert_y, o_vertex.vert_y);
                        mismatch_count++;
                    end
                    if (o_vertex.vert_z !== want.vert_z) begin
                        $error("vert_z: expected %0d, got %0d", want.vert_z, o_vertex.vert_z);
                        mismatch_count++;
                    end
                    if (o_vertex.tex_s !== want.tex_s) begin
                        $error("tex_s: expected %0d, got %0d", want.tex_s, o_vertex.tex_s);
                        mismatch_count++;
                    end
                    if (o_vertex.tex_t !== want.tex_t) begin
                        $error("tex_t: expected %0d, got %0d", want.tex_t, o_vertex.tex_t);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points under the reset setting: extremes, wrap and saturation.
        queue_point(make_point(0, 0, 0, 0, 0));
        queue_point(make_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 63, 0));
        queue_point(make_point(32'h80000000, 32'h80000000, 32'h80000000, 63, 4));
        queue_point(make_point(32'h80000000, 0, 0, 15, 8));
        queue_point(make_point(32'h00010000, 32'hFFFF0000, 0, 14, 16));
        queue_point(make_point(0, 32'h12345678, 32'h00010000, 16, 17));
        queue_point(make_point(32'h00030000, 1, 32'h00040000, 7, 127));
        queue_point(make_point(32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555, 1, 12));
        queue_point(make_point(32'h55555555, 32'h55555555, 32'hAAAAAAAA, 42, 3));
        queue_point(make_point(32'h40000000, 32'hDEADBEEF, 32'h40000000, 21, 64));
        queue_random(140);
        drain_all();

        // Smallest legal setting, then zero and out-of-range values.
        write_register(CFG_DIVISIONS, 1);
        write_register(CFG_PROFILE_POINTS, 2);
        queue_point(make_point(32'h00020000, 5, 0, 0, 0));
        queue_point(make_point(32'h00020000, 5, 0, 1, 1));
        queue_point(make_point(32'h00020000, 5, 0, 2, 2));
        queue_random(140);
        drain_all();

        write_register(CFG_DIVISIONS, 0);
        write_register(CFG_PROFILE_POINTS, 0);
        queue_point(make_point(32'h00050000, 0, 32'h00050000, 9, 1));
        queue_random(120);
        drain_all();

        write_register(CFG_DIVISIONS, 127);
        write_register(CFG_PROFILE_POINTS, 127);
        // long run with no idling on either side
        steady_stretch = 1'b1;
        queue_point(make_point(32'h00010000, 0, 0, 63, 64));
        queue_point(make_point(32'h00010000, 0, 0, 62, 65));
        queue_random(150);
        drain_all();
        steady_stretch = 1'b0;

        write_register(CFG_DIVISIONS, 64);
        write_register(CFG_PROFILE_POINTS, 64);
        queue_random(150);
        drain_all();

        write_register(CFG_DIVISIONS, 3);
        write_register(CFG_PROFILE_POINTS, 5);
        // writes past the register list must leave the setting alone
        write_register(t_cfg_idx'(2), 9);
        write_register(t_cfg_idx'(3), 127);
        queue_random(150);
        drain_all();

        write_register(CFG_PROFILE_POINTS, 1);
        queue_random(60);
        drain_all();

        if (mismatch_count == 0 && expected_vertices.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
